@@ hdl/rpi_pkg.sv @@
package rpi_pkg;

	localparam int CW     = 21;            // Q10.10 coordinate
	localparam int SW     = 22;            // origin minus corner
	localparam int PW     = 43;            // product and cross term
	localparam int YW     = 40;            // shifted cross product
	localparam int HW     = 20;            // low half of a split operand
	localparam int DW     = 62;            // dot product
	localparam int RW     = 61;            // dot magnitude and remainder
	localparam int BW     = 31;            // Q21.10 distance
	localparam int TW     = 31;            // distance quotient bits
	localparam int FW     = 17;            // Q1.16 local coordinate
	localparam int WW     = 18;            // third local coordinate
	localparam int NW     = 16;            // Q1.14 normal
	localparam int TSH    = 5;
	localparam int TINT   = 21;            // integer bits of the distance
	localparam int DIV_STAGES = TW;
	localparam int UV_STAGES  = FW;
	localparam int CFG_W  = 63;
	localparam int IDX_W  = 2;
	localparam int MW     = 30;            // normalized cross magnitude
	localparam int LW     = 32;            // length and its remainder
	localparam int QW     = 15;            // normal quotient bits
	localparam int NUMW   = 45;
	localparam int NFRAC  = 14;
	localparam int SQRT_TOP   = 60;
	localparam int SQRT_STEPS = 31;
	localparam int LAST_COMP  = 2;

	localparam logic [NW-1:0] NORM_ONE = NW'(16384);
	localparam logic [WW-1:0] W_ONE    = WW'(65536);

	typedef enum logic [IDX_W-1:0] {
		REG_CORNER = 2'd0,
		REG_EDGE1  = 2'd1,
		REG_EDGE2  = 2'd2
	} rpi_reg_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_CROSS,
		N_SHIFT,
		N_SQUARE,
		N_SQRT,
		N_DIVLD,
		N_DIV
	} rpi_nstate_t;

	typedef struct packed {
		logic                 degenerate;
		logic signed [NW-1:0] x;
		logic signed [NW-1:0] y;
		logic signed [NW-1:0] z;
	} rpi_normal_t;

	typedef struct packed {
		logic            miss;
		logic [BW-1:0]   best;
		logic [RW-1:0]   den;
		logic [TINT-1:0] tbits;
		logic [RW-1:0]   t_r;
		logic [TW-1:0]   t_q;
		logic [RW-1:0]   u_r;
		logic            ubit;
		logic [FW-1:0]   u_q;
		logic [RW-1:0]   v_r;
		logic            vbit;
		logic [FW-1:0]   v_q;
	} rpi_div_t;

	function automatic logic signed [CW-1:0] vcomp(logic [CFG_W-1:0] w, int i);
		return w[i*CW +: CW];
	endfunction

	// one restoring step: quotient bit on top, new remainder below
	function automatic logic [RW:0] div_step(logic [RW-1:0] r, logic [RW-1:0] d, logic b);
		logic [RW:0] r2;
		logic [RW:0] diff;
		r2   = {r, b};
		diff = r2 - {1'b0, d};
		if (r2 >= {1'b0, d}) begin
			return {1'b1, diff[RW-1:0]};
		end
		return {1'b0, r2[RW-1:0]};
	endfunction

endpackage

@@ hdl/ray_parallelogram_intersect_unit.sv @@
// Ray against parallelogram test, one ray per clock while busy is low. A ray is taken
// whenever start is high and busy is low, and its result appears on the result ports for one
// cycle with done high after eight arithmetic stages (offset, cross products, shift, split
// multiplies, recombine, dot sums, sign fix, overflow check), 31 restoring divider stages that
// produce the distance and both local coordinates, and the output register. Rays stream back
// to back and results leave in order; there is no way to hold a result off, so it must be
// taken when done is high. A write on the configuration channel starts a sequential pass over
// the edges that builds the unit normal (cross product, scaling, 31-step square root, three
// 15-step divides); busy and a low cfg_ready cover that pass.
module ray_parallelogram_intersect_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [rpi_pkg::CW-1:0] origin_x,
	input  logic signed [rpi_pkg::CW-1:0] origin_y,
	input  logic signed [rpi_pkg::CW-1:0] origin_z,
	input  logic signed [rpi_pkg::CW-1:0] dir_x,
	input  logic signed [rpi_pkg::CW-1:0] dir_y,
	input  logic signed [rpi_pkg::CW-1:0] dir_z,
	input  logic [rpi_pkg::BW-1:0]        best_so_far,
	output logic                          done,
	output logic                          hit,
	output logic [rpi_pkg::BW-1:0]        distance,
	output logic [rpi_pkg::FW-1:0]        coord_u,
	output logic [rpi_pkg::FW-1:0]        coord_v,
	output logic signed [rpi_pkg::WW-1:0] coord_w,
	output logic signed [rpi_pkg::NW-1:0] normal_x,
	output logic signed [rpi_pkg::NW-1:0] normal_y,
	output logic signed [rpi_pkg::NW-1:0] normal_z,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rpi_pkg::IDX_W-1:0]     cfg_index,
	input  logic [rpi_pkg::CFG_W-1:0]     cfg_data
);
	import rpi_pkg::*;

	logic [CFG_W-1:0] corner_q, edge1_q, edge2_q;
	logic             nbusy;
	logic             cfg_fire;
	rpi_normal_t      nrm;

	assign cfg_ready = !nbusy;
	assign busy      = nbusy;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
			edge1_q  <= '0;
			edge2_q  <= '0;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_CORNER: corner_q <= cfg_data;
				REG_EDGE1:  edge1_q  <= cfg_data;
				REG_EDGE2:  edge2_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	rpi_normal_unit u_normal (
		.clk         (clk),
		.arst_n      (arst_n),
		.recalc      (cfg_fire),
		.first_edge  (edge1_q),
		.second_edge (edge2_q),
		.busy        (nbusy),
		.nrm         (nrm)
	);

	logic     f_valid;
	rpi_div_t f_st;

	rpi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !nbusy),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.origin_z    (origin_z),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.dir_z       (dir_z),
		.best_so_far (best_so_far),
		.corner      (corner_q),
		.first_edge  (edge1_q),
		.second_edge (edge2_q),
		.out_valid   (f_valid),
		.out_st      (f_st)
	);

	logic     d_valid;
	rpi_div_t d_st;

	rpi_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_st     (f_st),
		.out_valid (d_valid),
		.out_st    (d_st)
	);

	// final distance compare against the previous best, folded with the earlier miss and degenerate flags
	logic          miss;
	logic [WW-1:0] w_raw;

	always_comb begin
		miss = d_st.miss || nrm.degenerate || (d_st.t_q > d_st.best) ||
			((d_st.t_q == d_st.best) && (d_st.t_r != '0));
		w_raw = WW'(d_st.u_q) - WW'(d_st.v_q) - W_ONE;
	end

	logic                 done_q;
	logic                 hit_q;
	logic [BW-1:0]        dist_q;
	logic [FW-1:0]        u_q, v_q;
	logic signed [WW-1:0] w_q;
	logic signed [NW-1:0] nx_q, ny_q, nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_valid;
		end
	end

	// drop every field to zero on a miss
	always_ff @(posedge clk) begin
		hit_q  <= !miss;
		dist_q <= miss ? '0 : d_st.t_q;
		u_q    <= miss ? '0 : d_st.u_q;
		v_q    <= miss ? '0 : d_st.v_q;
		w_q    <= miss ? '0 : $signed(w_raw);
		nx_q   <= miss ? '0 : nrm.x;
		ny_q   <= miss ? '0 : nrm.y;
		nz_q   <= miss ? '0 : nrm.z;
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign distance = dist_q;
	assign coord_u  = u_q;
	assign coord_v  = v_q;
	assign coord_w  = w_q;
	assign normal_x = nx_q;
	assign normal_y = ny_q;
	assign normal_z = nz_q;

endmodule

@@ hdl/rpi_normal_unit.sv @@
module rpi_normal_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        recalc,
	input  logic [rpi_pkg::CFG_W-1:0]   first_edge,
	input  logic [rpi_pkg::CFG_W-1:0]   second_edge,
	output logic                        busy,
	output rpi_pkg::rpi_normal_t        nrm
);
	import rpi_pkg::*;

	rpi_nstate_t state_q, state_d;
	logic [1:0]    cnt_q;
	logic [4:0]    step_q;
	logic [PW-1:0] mag_q [3];
	logic          sign_q [3];
	logic [DW-1:0] sum_q, x_q, res_q, bit_q;
	logic [LW-1:0] len_q, r_q;
	logic [QW-1:0] num_q, q_q;
	rpi_normal_t   nrm_q;

	logic signed [CW-1:0] a0, b0, a1, b1;
	logic signed [PW-1:0] c;
	logic [PW-1:0]        cmag;
	logic                 big;
	logic [MW-1:0]        msel;
	logic                 ssel;
	logic [2*MW-1:0]      sq;
	logic [DW-1:0]        trial;
	logic [LW:0]          r2;
	logic                 qbit;
	logic [QW-1:0]        qfin;
	logic [NW-1:0]        nmag;
	logic signed [NW-1:0] nsig;
	logic [NUMW-1:0]      num;
	logic                 last_comp;

	always_comb begin
		a0 = '0;
		b0 = '0;
		a1 = '0;
		b1 = '0;
		msel = '0;
		ssel = 1'b0;
		case (cnt_q)
			2'd0: begin
				a0 = vcomp(first_edge, 1);
				b0 = vcomp(second_edge, 2);
				a1 = vcomp(first_edge, 2);
				b1 = vcomp(second_edge, 1);
				msel = mag_q[0][MW-1:0];
				ssel = sign_q[0];
			end
			2'd1: begin
				a0 = vcomp(first_edge, 2);
				b0 = vcomp(second_edge, 0);
				a1 = vcomp(first_edge, 0);
				b1 = vcomp(second_edge, 2);
				msel = mag_q[1][MW-1:0];
				ssel = sign_q[1];
			end
			2'd2: begin
				a0 = vcomp(first_edge, 0);
				b0 = vcomp(second_edge, 1);
				a1 = vcomp(first_edge, 1);
				b1 = vcomp(second_edge, 0);
				msel = mag_q[2][MW-1:0];
				ssel = sign_q[2];
			end
			default: ;
		endcase
		c    = PW'(a0) * PW'(b0) - PW'(a1) * PW'(b1);
		cmag = (c < 0) ? PW'(-c) : PW'(c);
		big  = (|mag_q[0][PW-1:MW]) | (|mag_q[1][PW-1:MW]) | (|mag_q[2][PW-1:MW]);
		sq   = msel * msel;
		trial = res_q + bit_q;
		r2   = {r_q, num_q[QW-1]};
		qbit = r2 >= {1'b0, len_q};
		qfin = {q_q[QW-2:0], qbit};
		nmag = (NW'(qfin) > NORM_ONE) ? NORM_ONE : NW'(qfin);
		nsig = ssel ? -$signed(nmag) : $signed(nmag);
		num  = NUMW'({msel, {NFRAC{1'b0}}}) + NUMW'(res_q >> 1);
		last_comp = cnt_q == 2'(LAST_COMP);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			N_IDLE:   if (recalc) state_d = N_CROSS;
			N_CROSS:  if (last_comp) state_d = N_SHIFT;
			N_SHIFT:  if (!big) state_d = N_SQUARE;
			N_SQUARE: if (last_comp) state_d = N_SQRT;
			N_SQRT:   if (step_q == 5'(SQRT_STEPS - 1)) state_d = N_DIVLD;
			N_DIVLD:  state_d = (res_q == '0) ? N_IDLE : N_DIV;
			N_DIV: begin
				if (step_q == 5'(QW - 1)) begin
					state_d = last_comp ? N_IDLE : N_DIVLD;
				end
			end
			default:  state_d = N_IDLE;
		endcase
		busy = state_q != N_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			step_q <= '0;
			nrm_q  <= '{degenerate: 1'b1, x: '0, y: '0, z: '0};
		end else begin
			case (state_q)
				N_IDLE: begin
					cnt_q <= '0;
				end
				N_CROSS: begin
					cnt_q <= last_comp ? 2'd0 : cnt_q + 2'd1;
				end
				N_SQUARE: begin
					cnt_q  <= last_comp ? 2'd0 : cnt_q + 2'd1;
					step_q <= '0;
				end
				N_SQRT: begin
					step_q <= step_q + 5'd1;
				end
				N_DIVLD: begin
					step_q <= '0;
					if (res_q == '0) begin
						nrm_q.degenerate <= 1'b1;
					end
				end
				N_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(QW - 1)) begin
						case (cnt_q)
							2'd0:    nrm_q.x <= nsig;
							2'd1:    nrm_q.y <= nsig;
							default: nrm_q.z <= nsig;
						endcase
						if (last_comp) begin
							nrm_q.degenerate <= 1'b0;
						end
						cnt_q <= cnt_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_CROSS: begin
				case (cnt_q)
					2'd0: begin
						mag_q[0]  <= cmag;
						sign_q[0] <= c < 0;
					end
					2'd1: begin
						mag_q[1]  <= cmag;
						sign_q[1] <= c < 0;
					end
					default: begin
						mag_q[2]  <= cmag;
						sign_q[2] <= c < 0;
					end
				endcase
			end
			N_SHIFT: begin
				// scale all three together until each fits the squarer
				if (big) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end
				sum_q <= '0;
			end
			N_SQUARE: begin
				sum_q <= sum_q + DW'(sq);
				if (last_comp) begin
					x_q   <= sum_q + DW'(sq);
					res_q <= '0;
					bit_q <= DW'(1) << SQRT_TOP;
				end
			end
			N_SQRT: begin
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DIVLD: begin
				len_q <= res_q[LW-1:0];
				r_q   <= LW'(num[NUMW-1:QW]);
				num_q <= num[QW-1:0];
				q_q   <= '0;
			end
			N_DIV: begin
				r_q   <= qbit ? LW'(r2 - {1'b0, len_q}) : LW'(r2);
				num_q <= num_q << 1;
				q_q   <= qfin;
			end
			default: ;
		endcase
	end

	assign nrm = nrm_q;

endmodule

@@ hdl/rpi_front.sv @@
module rpi_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic signed [rpi_pkg::CW-1:0] origin_x,
	input  logic signed [rpi_pkg::CW-1:0] origin_y,
	input  logic signed [rpi_pkg::CW-1:0] origin_z,
	input  logic signed [rpi_pkg::CW-1:0] dir_x,
	input  logic signed [rpi_pkg::CW-1:0] dir_y,
	input  logic signed [rpi_pkg::CW-1:0] dir_z,
	input  logic [rpi_pkg::BW-1:0]      best_so_far,
	input  logic [rpi_pkg::CFG_W-1:0]   corner,
	input  logic [rpi_pkg::CFG_W-1:0]   first_edge,
	input  logic [rpi_pkg::CFG_W-1:0]   second_edge,
	output logic                        out_valid,
	output rpi_pkg::rpi_div_t           out_st
);
	import rpi_pkg::*;

	logic signed [CW-1:0] o_in [3];
	logic signed [CW-1:0] d_in [3];
	logic signed [CW-1:0] p_c [3];
	logic signed [CW-1:0] e1_c [3];
	logic signed [CW-1:0] e2_c [3];

	assign o_in[0] = origin_x;
	assign o_in[1] = origin_y;
	assign o_in[2] = origin_z;
	assign d_in[0] = dir_x;
	assign d_in[1] = dir_y;
	assign d_in[2] = dir_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_c[i]  = vcomp(corner, i);
			e1_c[i] = vcomp(first_edge, i);
			e2_c[i] = vcomp(second_edge, i);
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	// stage 1: offset from corner
	logic signed [SW-1:0] s_s1 [3];
	logic signed [CW-1:0] d_s1 [3];
	logic [BW-1:0] best_s1, best_s2, best_s3, best_s4, best_s5, best_s6, best_s7;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s1[i] <= SW'(o_in[i]) - SW'(p_c[i]);
			d_s1[i] <= d_in[i];
		end
		best_s1 <= best_so_far;
		best_s2 <= best_s1;
		best_s3 <= best_s2;
		best_s4 <= best_s3;
		best_s5 <= best_s4;
		best_s6 <= best_s5;
		best_s7 <= best_s6;
	end

	// stage 2: cross product terms of D x E2 and S x E1
	logic signed [PW-1:0] hp_s2 [3][2];
	logic signed [PW-1:0] qp_s2 [3][2];
	logic signed [SW-1:0] s_s2 [3], s_s3 [3];
	logic signed [CW-1:0] d_s2 [3], d_s3 [3];

	for (genvar i = 0; i < 3; i++) begin : g_cross
		localparam int J = (i == 2) ? 0 : i + 1;
		localparam int K = (i == 0) ? 2 : i - 1;
		always_ff @(posedge clk) begin
			hp_s2[i][0] <= PW'(d_s1[J]) * PW'(e2_c[K]);
			hp_s2[i][1] <= PW'(d_s1[K]) * PW'(e2_c[J]);
			qp_s2[i][0] <= PW'(s_s1[J]) * PW'(e1_c[K]);
			qp_s2[i][1] <= PW'(s_s1[K]) * PW'(e1_c[J]);
		end
	end

	// stage 3: differences, floor shift
	logic signed [YW-1:0] h_s3 [3];
	logic signed [YW-1:0] q_s3 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s2[i] <= s_s1[i];
			d_s2[i] <= d_s1[i];
			s_s3[i] <= s_s2[i];
			d_s3[i] <= d_s2[i];
			h_s3[i] <= YW'(((PW+1)'(hp_s2[i][0]) - (PW+1)'(hp_s2[i][1])) >>> TSH);
			q_s3[i] <= YW'(((PW+1)'(qp_s2[i][0]) - (PW+1)'(qp_s2[i][1])) >>> TSH);
		end
	end

	// stage 4: split partial products of the four dot products
	logic signed [SW-1:0] xs [4][3];
	logic signed [YW-1:0] ys [4][3];
	logic signed [PW-1:0] plo_s4 [4][3];
	logic signed [PW-1:0] phi_s4 [4][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xs[0][i] = SW'(e1_c[i]);
			ys[0][i] = h_s3[i];
			xs[1][i] = s_s3[i];
			ys[1][i] = h_s3[i];
			xs[2][i] = SW'(d_s3[i]);
			ys[2][i] = q_s3[i];
			xs[3][i] = SW'(e2_c[i]);
			ys[3][i] = q_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 4; n++) begin
			for (int i = 0; i < 3; i++) begin
				plo_s4[n][i] <= PW'(xs[n][i]) * PW'($signed({1'b0, ys[n][i][HW-1:0]}));
				phi_s4[n][i] <= PW'(xs[n][i]) * PW'($signed(ys[n][i][YW-1:HW]));
			end
		end
	end

	// stage 5: recombine halves; stage 6: sum components
	logic signed [DW-1:0] term_s5 [4][3];
	logic signed [DW-1:0] dot_s6 [4];

	always_ff @(posedge clk) begin
		for (int n = 0; n < 4; n++) begin
			for (int i = 0; i < 3; i++) begin
				term_s5[n][i] <= (DW'(phi_s4[n][i]) <<< HW) + DW'(plo_s4[n][i]);
			end
			dot_s6[n] <= term_s5[n][0] + term_s5[n][1] + term_s5[n][2];
		end
	end

	// stage 7: make the determinant positive, range checks
	logic                 neg7;
	logic signed [DW-1:0] nd [4];
	logic                 miss7;
	logic [RW-1:0]        mag_s7 [4];
	logic                 miss_s7;

	always_comb begin
		neg7 = dot_s6[0] < 0;
		for (int n = 0; n < 4; n++) begin
			nd[n] = neg7 ? -dot_s6[n] : dot_s6[n];
		end
		miss7 = (nd[0] == 0) || (nd[1] < 0) || (nd[1] > nd[0]) ||
			(nd[2] < 0) || (nd[2] > nd[0]) || (nd[3] <= 0);
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 4; n++) begin
			mag_s7[n] <= RW'(nd[n]);
		end
		miss_s7 <= miss7;
	end

	// stage 8: overflow check and divider seed
	rpi_div_t st8;
	logic     ovf8;

	always_comb begin
		ovf8      = (mag_s7[3] >> TINT) >= mag_s7[0];
		st8.miss  = miss_s7 || ovf8;
		st8.best  = best_s7;
		st8.den   = mag_s7[0];
		st8.tbits = mag_s7[3][TINT-1:0];
		st8.t_r   = mag_s7[3] >> TINT;
		st8.t_q   = '0;
		st8.u_r   = mag_s7[1] >> 1;
		st8.ubit  = mag_s7[1][0];
		st8.u_q   = '0;
		st8.v_r   = mag_s7[2] >> 1;
		st8.vbit  = mag_s7[2][0];
		st8.v_q   = '0;
	end

	always_ff @(posedge clk) begin
		out_st <= st8;
	end

	assign out_valid = v_s8;

endmodule

@@ hdl/rpi_divider.sv @@
module rpi_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rpi_pkg::rpi_div_t in_st,
	output logic              out_valid,
	output rpi_pkg::rpi_div_t out_st
);
	import rpi_pkg::*;

	rpi_div_t st  [1:DIV_STAGES];
	logic     vld [1:DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		rpi_div_t    cur;
		logic        cur_v;
		rpi_div_t    nx;
		logic [RW:0] ts, us, vs;

		if (k == 0) begin : g_first
			assign cur   = in_st;
			assign cur_v = in_valid;
		end else begin : g_next
			assign cur   = st[k];
			assign cur_v = vld[k];
		end

		always_comb begin
			ts = div_step(cur.t_r, cur.den, cur.tbits[TINT-1]);
			us = div_step(cur.u_r, cur.den, cur.ubit);
			vs = div_step(cur.v_r, cur.den, cur.vbit);
			nx = cur;
			nx.t_r   = ts[RW-1:0];
			nx.t_q   = {cur.t_q[TW-2:0], ts[RW]};
			nx.tbits = cur.tbits << 1;
			if (k < UV_STAGES) begin
				nx.u_r  = us[RW-1:0];
				nx.u_q  = {cur.u_q[FW-2:0], us[RW]};
				nx.ubit = 1'b0;
				nx.v_r  = vs[RW-1:0];
				nx.v_q  = {cur.v_q[FW-2:0], vs[RW]};
				nx.vbit = 1'b0;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else begin
				vld[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			st[k+1] <= nx;
		end
	end

	assign out_valid = vld[DIV_STAGES];
	assign out_st    = st[DIV_STAGES];

endmodule
